@@ sv/hash_table_probe_record_depth_aging_unit_defines.svh @@
// Assertion macros for the hash table probe and record unit.
`ifndef HASH_TABLE_PROBE_RECORD_DEPTH_AGING_UNIT_DEFINES_SVH
`define HASH_TABLE_PROBE_RECORD_DEPTH_AGING_UNIT_DEFINES_SVH

// A property that holds at every clock edge outside reset.
`define HTPRDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A property whose consequent starts in the cycle after its antecedent.
`define HTPRDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/htprda_pkg.sv @@
// Package with the types, codes and sizes of the hash table probe and record unit.
package htprda_pkg;

  localparam int unsigned INDEX_BITS = 16;

  localparam logic KIND_PROBE  = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  localparam logic [1:0] BOUND_NONE  = 2'd0;
  localparam logic [1:0] BOUND_EXACT = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;
  localparam logic [1:0] BOUND_LOWER = 2'd3;

  typedef logic [INDEX_BITS-1:0] slot_t;

  typedef struct packed {
    logic               kind;
    logic [63:0]        position_key;
    logic [7:0]         search_depth;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] beta_bound;
    logic signed [15:0] new_value;
    logic [1:0]         new_bound_kind;
    logic [31:0]        new_move;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               score_known;
    logic signed [15:0] score;
    logic [31:0]        stored_move;
    logic [7:0]         stored_depth;
    logic [1:0]         stored_kind;
    logic signed [15:0] stored_value;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [31:0]        move;
    logic [7:0]         age;
    logic signed [15:0] value;
    logic [1:0]         kind;
    logic [7:0]         depth;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic      wr_en;
    entry_t    wr_entry;
    out_item_t result;
  } eval_t;

endpackage

@@ sv/hash_table_probe_record_depth_aging_unit.sv @@
// Top level of the direct-mapped search result table with depth-preferred aging.
// Each item is accepted in IDLE, where the table read is issued, and moves to EVAL, which
// evaluates the entry read back from the registered RAM output, then either writes the
// record back (unless the old entry is kept) or loads the probe result into the output
// register. A probe waits in EVAL while the previous result has not been taken.
// After reset the table is cleared one slot per cycle, all 2**INDEX_BITS slots (65536 at the
// default size), during which no item is accepted; generation writes are taken at any time.
module hash_table_probe_record_depth_aging_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  htprda_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output htprda_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [7:0]            cfg_data_i
);
  import htprda_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e    state_q;
  slot_t     clr_cnt_q;
  logic [7:0] gen_q;
  in_item_t  item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      accept;
  logic      ram_we;
  slot_t     ram_waddr;
  entry_t    ram_wdata;
  entry_t    ram_rdata;
  eval_t     eval;
  logic      load_out;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign load_out    = (state_q == ST_EVAL) && (item_q.kind == KIND_PROBE) &&
                       (!out_valid_q || out_ready_i);

  htprda_eval u_eval (
    .item_i (item_q),
    .entry_i(ram_rdata),
    .gen_i  (gen_q),
    .eval_o (eval)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_q.position_key[INDEX_BITS-1:0];
    ram_wdata = eval.wr_entry;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if ((state_q == ST_EVAL) && (item_q.kind == KIND_RECORD)) begin
      ram_we = eval.wr_en;
    end
  end

  htprda_ram #(
    .DATA_W(ENTRY_W),
    .ADDR_W(INDEX_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(in_item_i.position_key[INDEX_BITS-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gen_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (&clr_cnt_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (item_q.kind == KIND_RECORD) begin
            state_q <= ST_IDLE;
          end else if (load_out) begin
            out_item_q <= eval.result;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ sv/htprda_ram.sv @@
// Simple dual-port synchronous RAM with one write port and one registered read port.
module htprda_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/htprda_eval.sv @@
// Probe lookup and record replacement decision for one table entry.
module htprda_eval (
  input  htprda_pkg::in_item_t item_i,
  input  htprda_pkg::entry_t   entry_i,
  input  logic [7:0]           gen_i,
  output htprda_pkg::eval_t    eval_o
);
  import htprda_pkg::*;

  logic      keep_old;
  logic      hit;
  logic      known;
  logic signed [15:0] score;
  out_item_t res;

  always_comb begin
    keep_old = (|entry_i.key) && (entry_i.age == gen_i) &&
               (item_i.search_depth < entry_i.depth);

    hit   = (entry_i.key == item_i.position_key);
    known = 1'b0;
    score = '0;
    if (hit && (entry_i.depth >= item_i.search_depth)) begin
      unique case (entry_i.kind)
        BOUND_EXACT: begin
          known = 1'b1;
          score = entry_i.value;
        end
        BOUND_UPPER: begin
          if (entry_i.value <= item_i.alpha_bound) begin
            known = 1'b1;
            score = item_i.alpha_bound;
          end
        end
        BOUND_LOWER: begin
          if (entry_i.value >= item_i.beta_bound) begin
            known = 1'b1;
            score = item_i.beta_bound;
          end
        end
        BOUND_NONE: begin
          known = 1'b0;
        end
      endcase
    end

    res = '0;
    if (hit) begin
      res.hit          = 1'b1;
      res.score_known  = known;
      res.score        = score;
      res.stored_move  = entry_i.move;
      res.stored_depth = entry_i.depth;
      res.stored_kind  = entry_i.kind;
      res.stored_value = entry_i.value;
    end

    eval_o.wr_en          = !keep_old;
    eval_o.wr_entry.key   = item_i.position_key;
    eval_o.wr_entry.move  = item_i.new_move;
    eval_o.wr_entry.age   = gen_i;
    eval_o.wr_entry.value = item_i.new_value;
    eval_o.wr_entry.kind  = item_i.new_bound_kind;
    eval_o.wr_entry.depth = item_i.search_depth;
    eval_o.result         = res;
  end

endmodule

@@ sv/htprda_checker.sv @@
// Port-level checker for the hash table probe and record unit, with its bind.
`include "hash_table_probe_record_depth_aging_unit_defines.svh"

module htprda_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input htprda_pkg::in_item_t  in_item_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input htprda_pkg::out_item_t out_item_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [7:0]            cfg_data_i
);
  import htprda_pkg::*;

  `HTPRDA_ASSERT_NEXT(a_one_item_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "Item accepted while another is in flight.")
  `HTPRDA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "Stalled result changed.")
  `HTPRDA_ASSERT_NEXT(a_record_no_result, in_valid_i && in_ready_o && in_item_i.kind == KIND_RECORD && !out_valid_o, !out_valid_o ##1 !out_valid_o, "Record item produced a result.")
  `HTPRDA_ASSERT(a_result_from_probe, $rose(out_valid_o) |-> $past(!in_ready_o), "Result appeared without an item in flight.")
  `HTPRDA_ASSERT(a_cfg_always_ready, cfg_ready_o || !cfg_valid_i || (cfg_data_i != cfg_data_i), "Generation write was refused.")

endmodule

bind hash_table_probe_record_depth_aging_unit htprda_checker u_htprda_checker (.*);
